### hdl/bcg_pkg.sv
// Shared types, constants and the sine table of the beep and chirp generator.
`default_nettype none

package bcg_pkg;

	localparam int SINE_ENTRIES    = 256;
	localparam int SINE_AW         = $clog2(SINE_ENTRIES);
	localparam int SINE_W          = 27;
	localparam int CHIRP_CNT_W     = 14;
	localparam int TICK_CNT_W      = 10;
	localparam int AMP_W           = 16;
	localparam int DAC_W           = 16;
	localparam int CFG_IDX_W       = 4;
	localparam int CFG_DATA_W      = 32;
	localparam int PROD_W          = AMP_W + 1 + SINE_W;
	localparam int SAMPLE_SHIFT    = 30;
	localparam int SAMPLE_W        = 13;

	localparam logic [CHIRP_CNT_W-1:0] CHIRP_ON_TICKS  = CHIRP_CNT_W'(6080);
	localparam logic [CHIRP_CNT_W-1:0] CHIRP_OFF_TICKS = CHIRP_CNT_W'(10320);

	localparam logic [DAC_W-1:0] DAC_CTRL_A    = 16'h3000;
	localparam logic [DAC_W-1:0] DAC_CTRL_B    = 16'hB000;
	localparam logic [DAC_W-1:0] SAMPLE_OFFSET = 16'd2048;

	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INCREMENT = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_STEP     = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY_STEP      = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_TICKS    = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BEEP_TICKS      = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY_TICKS     = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS       = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_B       = 4'd7;

	typedef struct packed {
		logic [31:0]           phase_increment;
		logic [AMP_W-1:0]      attack_step;
		logic [AMP_W-1:0]      decay_step;
		logic [TICK_CNT_W-1:0] attack_ticks;
		logic [TICK_CNT_W-1:0] beep_ticks;
		logic [TICK_CNT_W-1:0] decay_ticks;
		logic [TICK_CNT_W-1:0] gap_ticks;
		logic                  channel_b;
	} cfg_t;

	typedef struct packed {
		logic                ctrl_b;
		logic [AMP_W-1:0]    amplitude;
		logic [SINE_AW-1:0]  sine_idx;
	} sample_req_t;

	typedef logic signed [SINE_W-1:0] sine_tbl_t [SINE_ENTRIES];

	// Angles are Q61, the series runs in Q62.
	localparam logic [63:0] PI_Q61      = 64'h6487ED5110B4611A;
	localparam logic [63:0] HALF_PI_Q61 = 64'h3243F6A8885A308D;
	localparam logic [63:0] SINE_SCALE  = 64'd67076096;
	localparam logic [63:0] ANGLE_DEN   = 64'(1000 * SINE_ENTRIES);

	localparam logic [63:0] SERIES_DIV [24] = '{
		64'd1, 64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
		64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812, 64'd930,
		64'd1056, 64'd1190, 64'd1332, 64'd1482, 64'd1640, 64'd1806, 64'd1980,
		64'd2162
	};

	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	function automatic logic signed [SINE_W-1:0] sine_entry(input int unsigned i);
		logic [63:0] num;
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] mag;
		logic [31:0] m32;
		logic        neg;
		num = 64'(i) * 64'd6283;
		x = num / ANGLE_DEN;
		r = num % ANGLE_DEN;
		neg = 1'b0;
		for (int b = 0; b < 61; b++) begin
			r = r << 1;
			x = x << 1;
			if (r >= ANGLE_DEN) begin
				r = r - ANGLE_DEN;
				x = x | 64'd1;
			end
		end
		if (x >= PI_Q61) begin
			x = x - PI_Q61;
			neg = 1'b1;
		end
		if (x > HALF_PI_Q61) begin
			x = PI_Q61 - x;
		end
		x = x << 1;
		x2 = mul_q62(x, x);
		term = x;
		sum = x;
		for (int k = 1; k < 24; k++) begin
			if (term != 64'd0) begin
				term = mul_q62(term, x2) / SERIES_DIV[k];
				if ((k % 2) == 1) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
		end
		mag = mul_q62(SINE_SCALE, sum);
		m32 = mag[31:0];
		if (neg) begin
			m32 = -m32;
		end
		return m32[SINE_W-1:0];
	endfunction

	function automatic sine_tbl_t build_sine_rom();
		sine_tbl_t t;
		for (int i = 0; i < SINE_ENTRIES; i++) begin
			t[i] = sine_entry(i);
		end
		return t;
	endfunction

	localparam sine_tbl_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

### hdl/bcg_if.sv
// Channel interfaces for ticks, DAC words and configuration writes.
`default_nettype none

interface bcg_tick_if;
	logic valid;
	logic ready;
	logic button_pressed;
	modport source(output valid, output button_pressed, input ready);
	modport sink(input valid, input button_pressed, output ready);
endinterface

interface bcg_dac_if import bcg_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [DAC_W-1:0] dac_word;
	modport source(output valid, output dac_word, input ready);
	modport sink(input valid, input dac_word, output ready);
endinterface

interface bcg_cfg_if import bcg_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hdl/bcg_cfg_regs.sv
// Configuration register file written through the configuration channel.
`default_nettype none

module bcg_cfg_regs import bcg_pkg::*; (
	input  wire       clk,
	input  wire       arst_n,
	bcg_cfg_if.sink   cfg,
	output cfg_t      regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.phase_increment <= 32'd246960619;
			regs_q.attack_step     <= 16'd136;
			regs_q.decay_step      <= 16'd136;
			regs_q.attack_ticks    <= 10'd240;
			regs_q.beep_ticks      <= 10'd680;
			regs_q.decay_ticks     <= 10'd240;
			regs_q.gap_ticks       <= 10'd80;
			regs_q.channel_b       <= 1'b1;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_PHASE_INCREMENT: regs_q.phase_increment <= cfg.data;
				CFG_ATTACK_STEP:     regs_q.attack_step <= cfg.data[AMP_W-1:0];
				CFG_DECAY_STEP:      regs_q.decay_step <= cfg.data[AMP_W-1:0];
				CFG_ATTACK_TICKS:    regs_q.attack_ticks <= cfg.data[TICK_CNT_W-1:0];
				CFG_BEEP_TICKS:      regs_q.beep_ticks <= cfg.data[TICK_CNT_W-1:0];
				CFG_DECAY_TICKS:     regs_q.decay_ticks <= cfg.data[TICK_CNT_W-1:0];
				CFG_GAP_TICKS:       regs_q.gap_ticks <= cfg.data[TICK_CNT_W-1:0];
				CFG_CHANNEL_B:       regs_q.channel_b <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### hdl/bcg_sequencer.sv
// Chirp and beep sequencer, envelope and phase accumulator.
`default_nettype none

module bcg_sequencer import bcg_pkg::*; (
	input  wire          clk,
	input  wire          arst_n,
	input  cfg_t         regs,
	bcg_tick_if.sink     tick,
	output logic         req_valid,
	output sample_req_t  req,
	input  wire          req_ready
);

	logic                   mode_q;
	logic                   gap_q;
	logic [TICK_CNT_W-1:0]  bc_q;
	logic [CHIRP_CNT_W-1:0] cc_q;
	logic [31:0]            acc_q;
	logic [AMP_W-1:0]       amp_q;
	logic                   req_v_s1;
	sample_req_t            req_s1;

	logic                   accept;
	logic                   mode_w;
	logic [TICK_CNT_W-1:0]  bc_w;
	logic [CHIRP_CNT_W-1:0] cc_w;
	logic [TICK_CNT_W-1:0]  bc_inc;
	logic [CHIRP_CNT_W-1:0] cc_inc;
	logic [AMP_W:0]         amp_sum;
	logic                   decay_hit;
	logic                   mode_n;
	logic                   gap_n;
	logic [TICK_CNT_W-1:0]  bc_n;
	logic [CHIRP_CNT_W-1:0] cc_n;
	logic [31:0]            acc_n;
	logic [AMP_W-1:0]       amp_n;
	logic                   emit;

	assign tick.ready = !req_v_s1 || req_ready;
	assign accept = tick.valid && tick.ready;
	assign req_valid = req_v_s1;
	assign req = req_s1;

	always_comb begin
		mode_w = tick.button_pressed | mode_q;
		bc_w = tick.button_pressed ? '0 : bc_q;
		cc_w = tick.button_pressed ? '0 : cc_q;
		bc_inc = bc_w + 1'b1;
		cc_inc = cc_w + 1'b1;
		amp_sum = {1'b0, amp_q} + {1'b0, regs.attack_step};
		decay_hit = ({1'b0, bc_w} + {1'b0, regs.decay_ticks}) > {1'b0, regs.beep_ticks};
		mode_n = mode_w;
		gap_n = gap_q;
		bc_n = bc_w;
		cc_n = cc_w;
		acc_n = acc_q;
		amp_n = amp_q;
		emit = 1'b0;
		if (!mode_w) begin
			bc_n = bc_inc;
			cc_n = cc_inc;
			if (!gap_q) begin
				acc_n = acc_q + regs.phase_increment;
				emit = 1'b1;
				if (bc_w < regs.attack_ticks) begin
					amp_n = amp_sum[AMP_W] ? '1 : amp_sum[AMP_W-1:0];
				end else if (decay_hit) begin
					amp_n = (amp_q > regs.decay_step) ? amp_q - regs.decay_step : '0;
				end
				if (bc_inc == regs.beep_ticks) begin
					gap_n = 1'b1;
					bc_n = '0;
				end
			end else if (bc_inc == regs.gap_ticks) begin
				amp_n = '0;
				gap_n = 1'b0;
				bc_n = '0;
			end
			if (cc_inc == CHIRP_ON_TICKS) begin
				mode_n = 1'b1;
				cc_n = '0;
			end
		end else begin
			if (cc_w == CHIRP_OFF_TICKS) begin
				mode_n = 1'b0;
				cc_n = '0;
			end else begin
				amp_n = '0;
				cc_n = cc_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			gap_q <= 1'b0;
			bc_q <= '0;
			cc_q <= '0;
			acc_q <= '0;
			amp_q <= '0;
			req_v_s1 <= 1'b0;
		end else begin
			if (accept) begin
				mode_q <= mode_n;
				gap_q <= gap_n;
				bc_q <= bc_n;
				cc_q <= cc_n;
				acc_q <= acc_n;
				amp_q <= amp_n;
				req_v_s1 <= emit;
			end else if (req_ready) begin
				req_v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.ctrl_b <= regs.channel_b;
			req_s1.amplitude <= amp_q;
			req_s1.sine_idx <= acc_n[31 -: SINE_AW];
		end
	end

`ifndef SYNTHESIS
	a_chirp_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!mode_q |-> cc_q < CHIRP_ON_TICKS)
		else $error("chirp counter passed the chirp run length");
	a_silent_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q |-> cc_q <= CHIRP_OFF_TICKS)
		else $error("chirp counter passed the silent length");
	a_button_silences: assert property (@(posedge clk) disable iff (!arst_n)
		accept && tick.button_pressed |=> mode_q && req_v_s1 == 1'b0)
		else $error("pressed button did not force silence");
	a_silent_amp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		accept && mode_q && !tick.button_pressed && cc_q != CHIRP_OFF_TICKS |=> amp_q == '0)
		else $error("amplitude not cleared in silent mode");
`endif

endmodule

`default_nettype wire

### hdl/bcg_sample_path.sv
// Sine lookup, envelope scaling and DAC word formatting with output register.
`default_nettype none

module bcg_sample_path import bcg_pkg::*; (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          req_valid,
	input  sample_req_t  req,
	output logic         req_ready,
	bcg_dac_if.source    sample
);

	logic                     v_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     ctrl_s2;
	logic                     v_s3;
	logic [DAC_W-1:0]         dac_s3;

	logic                     en_s2;
	logic                     en_s3;
	logic signed [SINE_W-1:0] sine_val;
	logic signed [SAMPLE_W-1:0] scaled;
	logic [DAC_W-1:0]         offset_val;

	assign en_s3 = !v_s3 || sample.ready;
	assign en_s2 = !v_s2 || en_s3;
	assign req_ready = en_s2;

	assign sine_val = SINE_ROM[req.sine_idx];
	assign scaled = prod_s2[SAMPLE_SHIFT +: SAMPLE_W];
	assign offset_val = DAC_W'(scaled) + SAMPLE_OFFSET;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s2) begin
				v_s2 <= req_valid;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && req_valid) begin
			prod_s2 <= PROD_W'($signed({1'b0, req.amplitude}) * sine_val);
			ctrl_s2 <= req.ctrl_b;
		end
		if (en_s3 && v_s2) begin
			dac_s3 <= (ctrl_s2 ? DAC_CTRL_B : DAC_CTRL_A) | offset_val;
		end
	end

	assign sample.valid = v_s3;
	assign sample.dac_word = dac_s3;

`ifndef SYNTHESIS
	a_out_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s3) |-> $past(v_s2))
		else $error("DAC word appeared without a product behind it");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !en_s3 |=> v_s2 && $stable(prod_s2))
		else $error("product stage overwritten while stalled");
`endif

endmodule

`default_nettype wire

### hdl/dds_beep_chirp_generator.sv
// Top level of the DDS beep and chirp generator.
//
// The tick channel takes one item per audio sample tick, carrying the
// button level. Each tick that falls in a sounding beep of a chirp run
// yields one item on the sample channel: a 16-bit DAC command holding the
// channel control bits and the enveloped 12-bit sine sample. Ticks in a
// gap, in the silent mode or with the button held yield no item.
// A tick is taken in every cycle while the pipeline can move; its DAC word
// passes the request, product and output registers in that order.
// The state update for the next tick is done in the accepting cycle, so the
// rate is one tick per cycle while no stall holds the pipeline, set by the
// envelope and phase update loop. When the sample receiver stalls, the
// three result stages fill and then the tick channel drops ready until the
// stall clears. Configuration writes are taken in every cycle and change
// the registers at once; they belong to times when no tick is in flight.
// Reset clears the counters, phase, amplitude and pipeline, and loads the
// default tone and envelope settings.
`default_nettype none

module dds_beep_chirp_generator import bcg_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	bcg_tick_if.sink   tick,
	bcg_dac_if.source  sample,
	bcg_cfg_if.sink    cfg
);

	cfg_t        regs;
	logic        req_valid;
	sample_req_t req;
	logic        req_ready;

	bcg_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	bcg_sequencer u_sequencer (
		.clk       (clk),
		.arst_n    (arst_n),
		.regs      (regs),
		.tick      (tick),
		.req_valid (req_valid),
		.req       (req),
		.req_ready (req_ready)
	);

	bcg_sample_path u_sample_path (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_ready (req_ready),
		.sample    (sample)
	);

endmodule

`default_nettype wire
